>>> design/cpmi_pkg.sv
// shared types and constants of the cubic periodic minimum-image unit
package cpmi_pkg;

  localparam int LEN_WIDTH   = 31;
  localparam int RECIP_WIDTH = 48;
  localparam int RECIP_HALF  = RECIP_WIDTH / 2;
  localparam int DSQ_WIDTH   = 64;
  localparam int CFG_DATA_W  = RECIP_WIDTH;
  localparam int CFG_IDX_W   = 1;
  localparam int NUM_STAGES  = 10;

  localparam logic [LEN_WIDTH-1:0]   BOX_LENGTH_RST = LEN_WIDTH'(65536);
  localparam logic [RECIP_WIDTH-1:0] BOX_RECIP_RST  = RECIP_WIDTH'(64'h1_0000_0000);

  typedef enum logic [2:0] {
    OP_MIN_VEC      = 3'd0,
    OP_MIN_IMAGE    = 3'd1,
    OP_DIST_SQ      = 3'd2,
    OP_FOLD         = 3'd3,
    OP_FOLD_FRAC    = 3'd4,
    OP_FRAC_TO_REAL = 3'd5
  } op_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_BOX_LENGTH = 1'b0,
    REG_BOX_RECIP  = 1'b1
  } cfg_reg_e;

endpackage

>>> design/cpmi_axis.sv
// one axis of the wrap, fold and scale datapath, pipeline stages 0 to 7
module cpmi_axis import cpmi_pkg::*; #(
  parameter int COORD_WIDTH = 32,
  parameter int FRAC_BITS   = 16
) (
  input  logic                          clk_i,
  input  logic [NUM_STAGES-1:0]         en_i,
  input  op_e                           op_in_i,
  input  op_e                           op_i [NUM_STAGES],
  input  logic signed [COORD_WIDTH-1:0] first_i,
  input  logic signed [COORD_WIDTH-1:0] second_i,
  input  logic [LEN_WIDTH-1:0]          box_length_i,
  input  logic [RECIP_WIDTH-1:0]        box_recip_i,
  output logic signed [COORD_WIDTH-1:0] res_o
);

  localparam int CW  = COORD_WIDTH;
  localparam int AW  = CW + 1;
  localparam int PF  = 3 * FRAC_BITS;
  localparam int RF  = 2 * FRAC_BITS;
  localparam int PPW = AW + RECIP_HALF;
  localparam int PW  = AW + RECIP_WIDTH;
  localparam int PSW = ((PW > PF) ? PW : PF) + 1;
  localparam int NW  = PSW - PF;
  localparam int MNW = NW + LEN_WIDTH;
  localparam int MW  = (MNW > AW) ? MNW : AW;
  localparam int FH  = (PF + 1) / 2;
  localparam int FHI = PF - FH;
  localparam int FSW = PF + LEN_WIDTH;
  localparam int PLW = AW + LEN_WIDTH;
  localparam int Q5W = PLW + 1 - FRAC_BITS;
  localparam int VW  = CW + 2;
  localparam int X1  = (MW > LEN_WIDTH) ? MW : LEN_WIDTH;
  localparam int X2  = (X1 > Q5W) ? X1 : Q5W;
  localparam int X3  = (X2 > FRAC_BITS) ? X2 : FRAC_BITS;
  localparam int XW  = ((X3 > VW) ? X3 : VW) + 1;

  localparam logic signed [CW+2:0] CHI = {4'b0000, {(CW-1){1'b1}}};
  localparam logic signed [CW+2:0] CLO = ~CHI;

  function automatic logic [VW-1:0] sat_sm(input logic neg, input logic [XW-1:0] mag,
                                           input logic wide);
    logic [XW-1:0] lim;
    logic [XW-1:0] r;
    lim = wide ? (XW'(1) << (CW + 1)) : (XW'(1) << (CW - 1));
    if (neg) begin
      r = (mag > lim) ? lim : mag;
      r = ~r + 1'b1;
    end else begin
      r = (mag >= lim) ? (lim - 1'b1) : mag;
    end
    return r[VW-1:0];
  endfunction

  // carried operands
  logic [AW-1:0]                a_q  [5];
  logic                         s_q  [6];
  logic signed [CW-1:0]         r2_q [7];
  logic [Q5W-1:0]               q5_q [2:5];

  // stage 0
  logic signed [AW-1:0] r1x, r2x, dv;
  logic [AW-1:0]        du, a_d;

  always_comb begin
    r1x = {first_i[CW-1], first_i};
    r2x = {second_i[CW-1], second_i};
    case (op_in_i)
      OP_MIN_IMAGE:          dv = r1x - r2x;
      OP_MIN_VEC, OP_DIST_SQ: dv = r2x - r1x;
      default:               dv = r1x;
    endcase
    du  = dv;
    a_d = dv[AW-1] ? (~du + 1'b1) : du;
  end

  always_ff @(posedge clk_i) begin
    if (en_i[0]) begin
      a_q[0]  <= a_d;
      s_q[0]  <= dv[AW-1];
      r2_q[0] <= second_i;
    end
    for (int k = 1; k < 5; k++) begin
      if (en_i[k]) a_q[k] <= a_q[k-1];
    end
    for (int k = 1; k < 6; k++) begin
      if (en_i[k]) s_q[k] <= s_q[k-1];
    end
    for (int k = 1; k < 7; k++) begin
      if (en_i[k]) r2_q[k] <= r2_q[k-1];
    end
  end

  // stage 1: partial products of |d| with the reciprocal, and |r1| with the length
  logic [PPW-1:0] ppl_q, pph_q;
  logic [PLW-1:0] pl_q;

  always_ff @(posedge clk_i) begin
    if (en_i[1]) begin
      ppl_q <= PPW'(a_q[0]) * PPW'(box_recip_i[RECIP_HALF-1:0]);
      pph_q <= PPW'(a_q[0]) * PPW'(box_recip_i[RECIP_WIDTH-1:RECIP_HALF]);
      pl_q  <= PLW'(a_q[0]) * PLW'(box_length_i);
    end
  end

  // stage 2: full product, rounded real scale
  logic [PW-1:0]  p_d, p_q;
  logic [PLW:0]   q5s;

  always_comb begin
    p_d = PW'(ppl_q) + (PW'(pph_q) << RECIP_HALF);
    q5s = (PLW+1)'(pl_q) + ((PLW+1)'(1) << (FRAC_BITS - 1));
  end

  always_ff @(posedge clk_i) begin
    if (en_i[2]) begin
      p_q     <= p_d;
      q5_q[2] <= Q5W'(q5s >> FRAC_BITS);
    end
    for (int k = 3; k < 6; k++) begin
      if (en_i[k]) q5_q[k] <= q5_q[k-1];
    end
  end

  // stage 3: image count and fraction
  logic [PSW-1:0] pe, psum;
  logic [PF-1:0]  low, frac_d, frac_q;
  logic [NW-1:0]  n_q;

  always_comb begin
    pe     = PSW'(p_q);
    psum   = pe + (PSW'(1) << (PF - 1));
    low    = pe[PF-1:0];
    frac_d = (s_q[2] && (low != '0)) ? (~low + 1'b1) : low;
  end

  always_ff @(posedge clk_i) begin
    if (en_i[3]) begin
      n_q    <= NW'(psum >> PF);
      frac_q <= frac_d;
    end
  end

  // stage 4: image offset and fold partial products
  logic [MNW-1:0]           m_q;
  logic [FH+LEN_WIDTH-1:0]  fll_q;
  logic [FHI+LEN_WIDTH-1:0] flh_q;
  logic [FRAC_BITS-1:0]     ff4_q, ff5_q;

  always_ff @(posedge clk_i) begin
    if (en_i[4]) begin
      m_q   <= MNW'(n_q) * MNW'(box_length_i);
      fll_q <= (FH+LEN_WIDTH)'(frac_q[FH-1:0]) * (FH+LEN_WIDTH)'(box_length_i);
      flh_q <= (FHI+LEN_WIDTH)'(frac_q[PF-1:FH]) * (FHI+LEN_WIDTH)'(box_length_i);
      ff4_q <= FRAC_BITS'(frac_q >> RF);
    end
  end

  // stage 5: wrapped difference, folded coordinate
  logic [MW-1:0]        ae, me, mag_d, mag_q;
  logic                 neg_d, neg_q;
  logic [FSW-1:0]       fsum;
  logic [LEN_WIDTH-1:0] fm_q;

  always_comb begin
    ae = MW'(a_q[4]);
    me = MW'(m_q);
    if (ae >= me) begin
      mag_d = ae - me;
      neg_d = s_q[4];
    end else begin
      mag_d = me - ae;
      neg_d = !s_q[4];
    end
    fsum = FSW'(fll_q) + (FSW'(flh_q) << FH);
  end

  always_ff @(posedge clk_i) begin
    if (en_i[5]) begin
      mag_q <= mag_d;
      neg_q <= neg_d;
      fm_q  <= LEN_WIDTH'(fsum >> PF);
      ff5_q <= ff4_q;
    end
  end

  // stage 6: mode select and saturation
  logic [VW-1:0]        val_d;
  logic signed [VW-1:0] val_q;

  always_comb begin
    case (op_i[5])
      OP_MIN_VEC, OP_DIST_SQ: val_d = sat_sm(neg_q, XW'(mag_q), 1'b0);
      OP_MIN_IMAGE:           val_d = sat_sm(neg_q, XW'(mag_q), 1'b1);
      OP_FOLD:                val_d = sat_sm(1'b0, XW'(fm_q), 1'b0);
      OP_FOLD_FRAC:           val_d = sat_sm(1'b0, XW'(ff5_q), 1'b0);
      OP_FRAC_TO_REAL:        val_d = sat_sm(s_q[5], XW'(q5_q[5]), 1'b0);
      default:                val_d = '0;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (en_i[6]) val_q <= val_d;
  end

  // stage 7: in minimum-image mode the image offset is added back to the second point and saturated
  logic signed [CW+2:0] img;
  logic signed [CW-1:0] res_d, res_q;

  always_comb begin
    img = {val_q[VW-1], val_q} + {{3{r2_q[6][CW-1]}}, r2_q[6]};
    case (op_i[6])
      OP_MIN_IMAGE: begin
        if (img > CHI)      res_d = CHI[CW-1:0];
        else if (img < CLO) res_d = CLO[CW-1:0];
        else                res_d = img[CW-1:0];
      end
      default: res_d = val_q[CW-1:0];
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (en_i[7]) res_q <= res_d;
  end

  assign res_o = res_q;

endmodule

>>> design/cpmi_dsq.sv
// squared length of the result vector in distance-squared mode (zero otherwise), pipeline stages 8 and 9
module cpmi_dsq import cpmi_pkg::*; #(
  parameter int COORD_WIDTH = 32
) (
  input  logic                          clk_i,
  input  logic [NUM_STAGES-1:0]         en_i,
  input  op_e                           op_i [NUM_STAGES],
  input  logic signed [COORD_WIDTH-1:0] res_i [3],
  output logic signed [COORD_WIDTH-1:0] res_o [3],
  output logic [DSQ_WIDTH-1:0]          dist_sq_o
);

  localparam int CW   = COORD_WIDTH;
  localparam int SQW  = 2 * CW;
  localparam int SUMW = ((SQW + 2) > (DSQ_WIDTH + 1)) ? (SQW + 2) : (DSQ_WIDTH + 1);

  logic [CW-1:0]        mag  [3];
  logic [SQW-1:0]       sq_q [3];
  logic signed [CW-1:0] r8_q [3];
  logic signed [CW-1:0] r9_q [3];
  logic [SUMW-1:0]      sum;
  logic [DSQ_WIDTH-1:0] dsq_q;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      mag[i] = res_i[i][CW-1] ? (~res_i[i] + 1'b1) : res_i[i];
    end
    sum = SUMW'(sq_q[0]) + SUMW'(sq_q[1]) + SUMW'(sq_q[2]);
  end

  always_ff @(posedge clk_i) begin
    if (en_i[8]) begin
      for (int i = 0; i < 3; i++) begin
        r8_q[i] <= res_i[i];
        sq_q[i] <= (op_i[7] == OP_DIST_SQ) ? (SQW'(mag[i]) * SQW'(mag[i])) : '0;
      end
    end
    if (en_i[9]) begin
      for (int i = 0; i < 3; i++) begin
        r9_q[i] <= r8_q[i];
      end
      dsq_q <= (sum[SUMW-1:DSQ_WIDTH] != '0) ? '1 : sum[DSQ_WIDTH-1:0];
    end
  end

  assign res_o     = r9_q;
  assign dist_sq_o = dsq_q;

endmodule

>>> design/cubic_periodic_minimum_image.sv
// top level of the cubic periodic minimum-image unit: control, box registers, lanes
//
//  channel | direction | handshake                  | payload
//  in      | in        | in_valid_i / in_stall_o    | opcode, first_xyz, second_xyz
//  out     | out       | out_valid_o / out_stall_i  | res_xyz, dist_sq
//  cfg     | in        | cfg_we_i                   | cfg_index_i, cfg_data_i
//
//  one beat per cycle sustained while out_stall_i is low; each beat moves through the stages to the result register
//  the ten register stages each carry a valid bit; empty stages fill while the output waits
//  in_stall_o is high only when every stage holds a beat and out_stall_i is high
//  reset clears the valid bits and sets box length and reciprocal to one
module cubic_periodic_minimum_image import cpmi_pkg::*; #(
  parameter int COORD_WIDTH = 32,
  parameter int FRAC_BITS   = 16
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic [2:0]                    opcode_i,
  input  logic signed [COORD_WIDTH-1:0] first_x_i,
  input  logic signed [COORD_WIDTH-1:0] first_y_i,
  input  logic signed [COORD_WIDTH-1:0] first_z_i,
  input  logic signed [COORD_WIDTH-1:0] second_x_i,
  input  logic signed [COORD_WIDTH-1:0] second_y_i,
  input  logic signed [COORD_WIDTH-1:0] second_z_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic signed [COORD_WIDTH-1:0] res_x_o,
  output logic signed [COORD_WIDTH-1:0] res_y_o,
  output logic signed [COORD_WIDTH-1:0] res_z_o,
  output logic [DSQ_WIDTH-1:0]          dist_sq_o,
  input  logic                          cfg_we_i,
  input  logic [CFG_IDX_W-1:0]          cfg_index_i,
  input  logic [CFG_DATA_W-1:0]         cfg_data_i
);

  logic [LEN_WIDTH-1:0]   box_length_q;
  logic [RECIP_WIDTH-1:0] box_recip_q;
  logic [NUM_STAGES-1:0]  valid_q, en;
  logic                   go;
  op_e                    op_in;
  op_e                    op_q [NUM_STAGES];

  logic signed [COORD_WIDTH-1:0] first  [3];
  logic signed [COORD_WIDTH-1:0] second [3];
  logic signed [COORD_WIDTH-1:0] lane_res [3];
  logic signed [COORD_WIDTH-1:0] out_res  [3];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      box_length_q <= BOX_LENGTH_RST;
      box_recip_q  <= BOX_RECIP_RST;
    end else if (cfg_we_i) begin
      case (cfg_reg_e'(cfg_index_i))
        REG_BOX_LENGTH: box_length_q <= cfg_data_i[LEN_WIDTH-1:0];
        REG_BOX_RECIP:  box_recip_q  <= cfg_data_i[RECIP_WIDTH-1:0];
        default: ;
      endcase
    end
  end

  // a stage moves when it is empty or the one after it moves
  always_comb begin
    go = !out_stall_i;
    for (int k = NUM_STAGES - 1; k >= 0; k--) begin
      en[k] = !valid_q[k] || go;
      go    = en[k];
    end
  end

  assign in_stall_o  = !en[0];
  assign out_valid_o = valid_q[NUM_STAGES-1];
  assign op_in       = op_e'(opcode_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else begin
      if (en[0]) valid_q[0] <= in_valid_i;
      for (int k = 1; k < NUM_STAGES; k++) begin
        if (en[k]) valid_q[k] <= valid_q[k-1];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en[0]) op_q[0] <= op_in;
    for (int k = 1; k < NUM_STAGES; k++) begin
      if (en[k]) op_q[k] <= op_q[k-1];
    end
  end

  assign first[0]  = first_x_i;
  assign first[1]  = first_y_i;
  assign first[2]  = first_z_i;
  assign second[0] = second_x_i;
  assign second[1] = second_y_i;
  assign second[2] = second_z_i;

  for (genvar i = 0; i < 3; i++) begin : g_axis
    cpmi_axis #(
      .COORD_WIDTH (COORD_WIDTH),
      .FRAC_BITS   (FRAC_BITS)
    ) u_axis (
      .clk_i        (clk_i),
      .en_i         (en),
      .op_in_i      (op_in),
      .op_i         (op_q),
      .first_i      (first[i]),
      .second_i     (second[i]),
      .box_length_i (box_length_q),
      .box_recip_i  (box_recip_q),
      .res_o        (lane_res[i])
    );
  end

  cpmi_dsq #(
    .COORD_WIDTH (COORD_WIDTH)
  ) u_dsq (
    .clk_i     (clk_i),
    .en_i      (en),
    .op_i      (op_q),
    .res_i     (lane_res),
    .res_o     (out_res),
    .dist_sq_o (dist_sq_o)
  );

  assign res_x_o = out_res[0];
  assign res_y_o = out_res[1];
  assign res_z_o = out_res[2];

endmodule

>>> tb/tb_cubic_periodic_minimum_image.sv
// testbench of the cubic periodic minimum-image unit: a table of beats, then random beats against a predictor
module tb_cubic_periodic_minimum_image;
  timeunit 1ns;
  timeprecision 1ps;
  import cpmi_pkg::*;

  localparam int CW             = 32;
  localparam int FB             = 16;
  localparam int RF             = 32;
  localparam int PF             = 48;
  localparam int DIRECTED       = 16;
  localparam int PHASES         = 8;
  localparam int RAND_PER_PHASE = 190;

  localparam logic [2:0] OP_SPARE_LO = 3'd6;
  localparam logic [2:0] OP_SPARE_HI = 3'd7;

  localparam logic [CW-1:0] Q_MAX     = 32'h7fff_ffff;
  localparam logic [CW-1:0] Q_MIN     = 32'h8000_0000;
  localparam logic [CW-1:0] Q_ONE     = 32'd65536;
  localparam logic [CW-1:0] Q_HALF    = 32'd32768;
  localparam logic [CW-1:0] Q_QUARTER = 32'd16384;
  localparam logic [CW-1:0] Q_THREE_Q = 32'd49152;
  localparam logic [CW-1:0] Q_ULP     = 32'd1;

  localparam logic signed [63:0] SAT_HI = 64'sh7fff_ffff;
  localparam logic signed [63:0] SAT_LO = -64'sh8000_0000;
  localparam logic [0:2][7:0]    AXIS_TAG = "xyz";

  typedef logic [127:0] wide_t;
  typedef logic [0:2][CW-1:0] point_t;

  typedef struct packed {
    point_t                 axis;
    logic [DSQ_WIDTH-1:0]   dsq;
  } image_res_t;

  typedef struct packed {
    logic [2:0] op;
    point_t     r1;
    point_t     r2;
    logic       typed;
    image_res_t want;
  } plan_row_t;

  logic                  clk_i       = 1'b0;
  logic                  rst_ni      = 1'b0;
  logic                  in_valid_i  = 1'b0;
  logic                  in_stall_o;
  logic [2:0]            opcode_i    = '0;
  logic signed [CW-1:0]  first_x_i   = '0;
  logic signed [CW-1:0]  first_y_i   = '0;
  logic signed [CW-1:0]  first_z_i   = '0;
  logic signed [CW-1:0]  second_x_i  = '0;
  logic signed [CW-1:0]  second_y_i  = '0;
  logic signed [CW-1:0]  second_z_i  = '0;
  logic                  out_valid_o;
  logic                  out_stall_i = 1'b0;
  logic signed [CW-1:0]  res_x_o;
  logic signed [CW-1:0]  res_y_o;
  logic signed [CW-1:0]  res_z_o;
  logic [DSQ_WIDTH-1:0]  dist_sq_o;
  logic                  cfg_we_i    = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index_i = REG_BOX_LENGTH;
  logic [CFG_DATA_W-1:0] cfg_data_i  = '0;

  logic [LEN_WIDTH-1:0]   edge_len   = BOX_LENGTH_RST;
  logic [RECIP_WIDTH-1:0] edge_recip = BOX_RECIP_RST;
  image_res_t             pending_images [$];
  image_res_t             head_res;
  image_res_t             seen_res;
  int                     mismatches = 0;
  logic [8:0]             stall_phase = '0;
  plan_row_t              plan [DIRECTED];

  cubic_periodic_minimum_image u_top (.*);

  always #6 clk_i = ~clk_i;

  function automatic wide_t abs_wide(input logic signed [63:0] v);
    return (v < 0) ? wide_t'(-v) : wide_t'(v);
  endfunction

  function automatic logic signed [63:0] clamp_sm(input logic neg, input wide_t mag,
                                                   input int k);
    wide_t lim;
    lim = wide_t'(1) << k;
    if (neg) return (mag > lim) ? -$signed(lim[63:0]) : -$signed(mag[63:0]);
    return (mag >= lim) ? $signed(lim[63:0] - 64'd1) : $signed(mag[63:0]);
  endfunction

  // d minus the nearest whole number of box lengths, as sign and magnitude
  function automatic wide_t wrap_mag(input logic signed [63:0] d, output logic neg);
    wide_t a, m;
    a = abs_wide(d);
    m = ((a * edge_recip + (wide_t'(1) << (PF - 1))) >> PF) * edge_len;
    if (a >= m) begin
      neg = d < 0;
      return a - m;
    end
    neg = !(d < 0);
    return m - a;
  endfunction

  function automatic wide_t fold_fraction(input logic signed [63:0] r);
    wide_t low;
    low = (abs_wide(r) * edge_recip) & ((wide_t'(1) << PF) - 1);
    if (r < 0 && low != 0) return (wide_t'(1) << PF) - low;
    return low;
  endfunction

  function automatic image_res_t predict_image(input logic [2:0] op, input point_t r1,
                                               input point_t r2);
    image_res_t         res;
    wide_t              mag, sumsq;
    logic               neg;
    logic signed [63:0] a1, a2, v;
    res   = '0;
    sumsq = '0;
    for (int i = 0; i < 3; i++) begin
      a1 = $signed(r1[i]);
      a2 = $signed(r2[i]);
      v  = '0;
      case (op)
        OP_MIN_VEC, OP_DIST_SQ: begin
          mag = wrap_mag(a2 - a1, neg);
          v   = clamp_sm(neg, mag, CW - 1);
        end
        OP_MIN_IMAGE: begin
          mag = wrap_mag(a1 - a2, neg);
          v   = clamp_sm(neg, mag, CW + 1) + a2;
          v   = (v > SAT_HI) ? SAT_HI : ((v < SAT_LO) ? SAT_LO : v);
        end
        OP_FOLD: begin
          v = clamp_sm(1'b0, (fold_fraction(a1) * edge_len) >> PF, CW - 1);
        end
        OP_FOLD_FRAC: begin
          v = clamp_sm(1'b0, fold_fraction(a1) >> RF, CW - 1);
        end
        OP_FRAC_TO_REAL: begin
          v = clamp_sm(a1 < 0, (abs_wide(a1) * edge_len + (wide_t'(1) << (FB - 1))) >> FB,
                       CW - 1);
        end
        default: begin
          v = '0;
        end
      endcase
      res.axis[i] = v[CW-1:0];
      mag         = abs_wide(v);
      sumsq       = sumsq + mag * mag;
    end
    if (op == OP_DIST_SQ) res.dsq = (sumsq[127:64] != 0) ? '1 : sumsq[63:0];
    return res;
  endfunction

  function automatic logic [CW-1:0] draw_coord();
    logic signed [CW-1:0] raw;
    raw = $urandom;
    case ($urandom_range(0, 4))
      0: return raw;
      1: begin
        case ($urandom_range(0, 4))
          0: return Q_MIN;
          1: return Q_MAX;
          2: return '0;
          3: return '1;
          default: return Q_ULP;
        endcase
      end
      default: return raw >>> $urandom_range(0, CW - 1);
    endcase
  endfunction

  // second point often sits a half-plus-whole number of box lengths away
  function automatic void draw_item(output logic [2:0] op, output point_t r1,
                                    output point_t r2);
    logic signed [63:0] span;
    logic signed [CW-1:0] jitter;
    int k;
    span = {33'b0, edge_len};
    if ($urandom_range(0, 19) == 0) op = 3'($urandom_range(OP_SPARE_LO, OP_SPARE_HI));
    else op = 3'($urandom_range(OP_MIN_VEC, OP_FRAC_TO_REAL));
    for (int i = 0; i < 3; i++) begin
      r1[i]  = draw_coord();
      r2[i]  = draw_coord();
      k      = $urandom_range(0, 6);
      jitter = $urandom;
      case ($urandom_range(0, 3))
        0: r2[i] = r1[i] + CW'((k - 3) * span + (span >>> 1));
        1: r2[i] = r1[i] - CW'((k - 3) * span + (span >>> 1));
        2: r2[i] = r1[i] + CW'(jitter >>> $urandom_range(8, CW - 1));
        default: ;
      endcase
    end
  endfunction

  task automatic send_beat(input logic [2:0] op, input point_t r1, input point_t r2,
                           input logic typed, input image_res_t want);
    in_valid_i <= 1'b1;
    opcode_i   <= op;
    first_x_i  <= r1[0];
    first_y_i  <= r1[1];
    first_z_i  <= r1[2];
    second_x_i <= r2[0];
    second_y_i <= r2[1];
    second_z_i <= r2[2];
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    pending_images.push_back(typed ? want : predict_image(op, r1, r2));
  endtask

  task automatic sender_gap(input int cycles);
    if (cycles > 0) begin
      in_valid_i <= 1'b0;
      repeat (cycles) @(posedge clk_i);
    end
  endtask

  task automatic set_box(input logic [LEN_WIDTH-1:0] len, input logic [RECIP_WIDTH-1:0] recip);
    in_valid_i <= 1'b0;
    while (pending_images.size() != 0) @(posedge clk_i);
    repeat (2) @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= REG_BOX_LENGTH;
    cfg_data_i  <= CFG_DATA_W'(len);
    @(posedge clk_i);
    edge_len    = len;
    cfg_index_i <= REG_BOX_RECIP;
    cfg_data_i  <= recip;
    @(posedge clk_i);
    edge_recip  = recip;
    cfg_we_i    <= 1'b0;
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_stall_i <= 1'b0;
      stall_phase <= '0;
    end else begin
      stall_phase <= stall_phase + 1'b1;
      case (stall_phase[8:7])
        2'd0: out_stall_i <= 1'b0;
        2'd1: out_stall_i <= $urandom_range(0, 1) == 0;
        2'd2: out_stall_i <= $urandom_range(0, 7) != 0;
        default: out_stall_i <= stall_phase[2:0] == 3'd5 || stall_phase[2:0] == 3'd6;
      endcase
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (pending_images.size() == 0) begin
        mismatches++;
        $display("%0t: result beat with none expected, actual x=%h y=%h z=%h dist_sq=%h",
                 $time, res_x_o, res_y_o, res_z_o, dist_sq_o);
      end else begin
        head_res = pending_images.pop_front();
        seen_res = {res_x_o, res_y_o, res_z_o, dist_sq_o};
        for (int a = 0; a < 3; a++) begin
          if (seen_res.axis[a] !== head_res.axis[a]) begin
            mismatches++;
            $display("%0t: res_%c expected %h actual %h", $time, AXIS_TAG[a],
                     head_res.axis[a], seen_res.axis[a]);
          end
        end
        if (seen_res.dsq !== head_res.dsq) begin
          mismatches++;
          $display("%0t: dist_sq expected %h actual %h", $time, head_res.dsq, seen_res.dsq);
        end
      end
    end
  end

  initial begin
    logic [2:0]             op;
    point_t                 r1, r2;
    int                     sent, burst;
    logic [LEN_WIDTH-1:0]   len;
    logic [RECIP_WIDTH-1:0] recip;

    // box of one, reciprocal of one, as after reset
    plan = '{
      '{OP_MIN_VEC, '{'0, '0, '0}, '{'0, '0, '0}, 1'b1, '{'{'0, '0, '0}, '0}},
      '{OP_MIN_VEC, '{'0, '0, '0}, '{Q_QUARTER, Q_HALF, -Q_HALF}, 1'b1,
        '{'{Q_QUARTER, -Q_HALF, Q_HALF}, '0}},
      '{OP_MIN_VEC, '{Q_MIN, Q_MIN, Q_MAX}, '{Q_MAX, Q_MAX, Q_MIN}, 1'b1,
        '{'{'1, '1, Q_ULP}, '0}},
      '{OP_MIN_VEC, '{-Q_HALF, Q_ONE + Q_HALF, Q_ULP}, '{Q_ULP, Q_ONE, '0}, 1'b0, '0},
      '{OP_MIN_IMAGE, '{Q_THREE_Q, '0, -Q_THREE_Q}, '{'0, '0, '0}, 1'b1,
        '{'{-Q_QUARTER, '0, Q_QUARTER}, '0}},
      '{OP_MIN_IMAGE, '{Q_MAX, Q_MIN, '0}, '{Q_MIN, Q_MAX, Q_MAX}, 1'b0, '0},
      '{OP_DIST_SQ, '{'0, '0, '0}, '{Q_QUARTER, Q_QUARTER, Q_HALF}, 1'b1,
        '{'{Q_QUARTER, Q_QUARTER, -Q_HALF}, 64'h6000_0000}},
      '{OP_DIST_SQ, '{Q_MIN, Q_MAX, '0}, '{Q_MAX, Q_MIN, Q_MIN}, 1'b0, '0},
      '{OP_FOLD, '{-Q_QUARTER, -Q_ONE, '0}, '{Q_MAX, Q_MIN, Q_ONE}, 1'b1,
        '{'{Q_THREE_Q, '0, '0}, '0}},
      '{OP_FOLD, '{Q_MAX, Q_MIN, Q_ONE + Q_THREE_Q}, '{'0, '0, '0}, 1'b0, '0},
      '{OP_FOLD_FRAC, '{Q_ONE + Q_THREE_Q, -Q_QUARTER, '0}, '{'1, '1, '1}, 1'b1,
        '{'{Q_THREE_Q, Q_THREE_Q, '0}, '0}},
      '{OP_FOLD_FRAC, '{Q_MIN, Q_MAX, '1}, '{'0, '0, '0}, 1'b0, '0},
      '{OP_FRAC_TO_REAL, '{5 * Q_HALF, Q_MIN, -(5 * Q_HALF)}, '{Q_MIN, Q_MAX, '0}, 1'b1,
        '{'{5 * Q_HALF, Q_MIN, -(5 * Q_HALF)}, '0}},
      '{OP_FRAC_TO_REAL, '{Q_MAX, Q_ULP, '1}, '{'0, '0, '0}, 1'b0, '0},
      '{OP_SPARE_LO, '{Q_MAX, Q_MAX, Q_MAX}, '{Q_MIN, Q_MIN, Q_MIN}, 1'b1, '0},
      '{OP_SPARE_HI, '{Q_MIN, '1, Q_ONE}, '{Q_MAX, Q_ULP, Q_HALF}, 1'b1, '0}
    };

    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    for (int n = 0; n < DIRECTED; n++) begin
      send_beat(plan[n].op, plan[n].r1, plan[n].r2, plan[n].typed, plan[n].want);
      sender_gap($urandom_range(0, 2));
    end

    for (int ph = 0; ph < PHASES; ph++) begin
      case (ph)
        1: set_box(LEN_WIDTH'(1), '1);
        2: set_box('1, RECIP_WIDTH'(1));
        3: set_box(LEN_WIDTH'(655360), RECIP_WIDTH'(429496730));
        4: set_box(LEN_WIDTH'(32'h0010_0000), RECIP_WIDTH'(32'h1000_0000));
        5: set_box('1, RECIP_WIDTH'(131072));
        6: begin
          len = LEN_WIDTH'($urandom_range(2, 65536 * 64));
          set_box(len, RECIP_WIDTH'((64'd1 << 48) / len));
        end
        7: begin
          len   = LEN_WIDTH'($urandom_range(1, 32'h7fff_ffff));
          recip = RECIP_WIDTH'({$urandom, $urandom});
          if (recip == '0) recip = RECIP_WIDTH'(1);
          set_box(len, recip);
        end
        default: ;
      endcase
      sent = 0;
      while (sent < RAND_PER_PHASE) begin
        burst = $urandom_range(1, 24);
        while (burst > 0 && sent < RAND_PER_PHASE) begin
          draw_item(op, r1, r2);
          send_beat(op, r1, r2, 1'b0, '0);
          sent++;
          burst--;
        end
        sender_gap(($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 7));
      end
    end

    in_valid_i <= 1'b0;
    while (pending_images.size() != 0) @(posedge clk_i);
    repeat (NUM_STAGES + 8) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

  initial begin
    #5ms;
    $display("CHECKS FAILED");
    $finish;
  end

endmodule
